// ===== hw/rtl/aswf_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive slerp weight filter package
// Shared widths, constants and the memory access struct.
// ----------------------------------------------------------------------------
package aswf_pkg;
    localparam int unsigned SAMPLE_W = 16;
    localparam logic [15:0] ONE_Q12  = 16'd4096;
    localparam logic [16:0] ONE_Q15  = 17'd32768;
    localparam logic [15:0] POWER_RESET = 16'd4096;

    localparam logic CFG_SLERP_POWER  = 1'b0;
    localparam logic CFG_ACCEL_ENABLE = 1'b1;

    typedef struct packed {
        logic        en;
        logic [15:0] data;
    } wr_ctl_t;
endpackage

// ===== hw/rtl/adaptive_slerp_weight_filter.sv =====
// ----------------------------------------------------------------------------
// Adaptive slerp weight filter
// Accelerometer error, adaptive averaging and recursive weight filter.
// ----------------------------------------------------------------------------
// A sequencer runs a 24-step bit-pair square root and walks the error ring
// memory and the weight ring memory at one read per cycle. A 48-step
// restoring divider handles the division by slerp_power. The divisions by
// the error ring length and by the weight sum WEIGHT_TAPS*(WEIGHT_TAPS+1)/2
// are reciprocal multiplications. A disabled sample bypasses the sequencer.
// After reset the two rings are cleared. A sample may be accepted during
// the clear but is not processed until the clear has finished. A result
// waits in the output register while the next sample is already accepted.
module adaptive_slerp_weight_filter #(
    parameter int ERROR_TAPS  = 10,
    parameter int WEIGHT_TAPS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // slerp_weight, bypassed, zero fill
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);
    import aswf_pkg::*;

    localparam int EA = $clog2(ERROR_TAPS);
    localparam int WA = $clog2(WEIGHT_TAPS);
    localparam int CLR = (ERROR_TAPS > WEIGHT_TAPS) ? ERROR_TAPS : WEIGHT_TAPS;
    localparam int CA = $clog2(CLR + 1);
    localparam int WDEN = WEIGHT_TAPS * (WEIGHT_TAPS + 1) / 2;
    // Reciprocals rounded up; exact for dividends below 2^24 and divisors
    // below 256.
    localparam logic [31:0] WREC =
        32'(((64'd1 << 32) + 64'(WDEN) - 64'd1) / 64'(WDEN));
    localparam logic [31:0] EREC =
        32'(((64'd1 << 32) + 64'(ERROR_TAPS) - 64'd1) / 64'(ERROR_TAPS));

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SQRT  = 4'd2;
    localparam logic [3:0] ST_WAVG  = 4'd3;
    localparam logic [3:0] ST_AVGD  = 4'd4;
    localparam logic [3:0] ST_ESUM  = 4'd5;
    localparam logic [3:0] ST_MEAND = 4'd6;
    localparam logic [3:0] ST_RAWD  = 4'd7;
    localparam logic [3:0] ST_WSUM  = 4'd8;
    localparam logic [3:0] ST_FILTD = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;
    localparam logic [3:0] ST_DIV   = 4'd11;
    localparam logic [3:0] ST_RECIP = 4'd12;

    logic [3:0]  state_reg, ret_reg;
    logic [15:0] power_reg;
    logic        enable_reg;
    logic [47:0] in_reg;
    logic        in_full_reg;
    logic        out_valid_reg;
    logic [16:0] out_weight_reg;
    logic        out_byp_reg;

    logic [EA-1:0] ehead_reg;
    logic [EA:0]   efill_reg;
    logic [WA-1:0] whead_reg;
    logic [WA:0]   wfill_reg;
    logic [CA-1:0] cnt_reg;

    logic [34:0] acc_reg;     // ring sums
    logic [17:0] root_reg;
    logic [5:0]  step_reg;
    logic [15:0] err_reg;
    logic        byp_reg;
    logic [16:0] raw_reg;
    logic [16:0] avg_reg;

    // Restoring divider for slerp_power: dividend in quo, remainder in rem.
    // quo also carries the radicand and the reciprocal products.
    logic [47:0] quo_reg;
    logic [16:0] rem_reg;
    logic [15:0] dvs_reg;
    logic [31:0] mul_reg;

    logic [EA-1:0] eraddr;
    logic [WA-1:0] wraddr;
    logic [15:0]   erdata, wrdata;
    wr_ctl_t       ewr, wwr;
    logic [EA-1:0] ewaddr;
    logic [WA-1:0] wwaddr;

    function automatic logic [EA-1:0] enext(input logic [EA-1:0] h);
        return (32'(h) + 1 >= ERROR_TAPS) ? '0 : EA'(32'(h) + 1);
    endfunction
    function automatic logic [WA-1:0] wnext(input logic [WA-1:0] h);
        return (32'(h) + 1 >= WEIGHT_TAPS) ? '0 : WA'(32'(h) + 1);
    endfunction

    aswf_ram #(.WIDTH(16), .DEPTH(ERROR_TAPS)) u_err_ram (
        .aclk(aclk), .we(ewr.en), .waddr(ewaddr), .wdata(ewr.data),
        .raddr(eraddr), .rdata(erdata)
    );
    aswf_ram #(.WIDTH(16), .DEPTH(WEIGHT_TAPS)) u_wgt_ram (
        .aclk(aclk), .we(wwr.en), .waddr(wwaddr), .wdata(wwr.data),
        .raddr(wraddr), .rdata(wrdata)
    );

    assign s_tready = !in_full_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_byp_reg, out_weight_reg[15:0]};

    // walk index: cnt counts reads issued
    logic [EA-1:0] eidx;
    logic [WA-1:0] widx;
    always_comb begin
        eidx = EA'(cnt_reg);
        widx = whead_reg;
        for (int i = 0; i < WEIGHT_TAPS; i++) begin
            if (i <= int'(cnt_reg)) begin
                widx = wnext(widx);
            end
        end
    end
    assign eraddr = (cnt_reg < CA'(ERROR_TAPS)) ? eidx : '0;
    assign wraddr = widx;

    // sqrt step signals
    logic [35:0] sq_x, sq_y, sq_z;
    logic [19:0] trial;
    always_comb begin
        sq_x = 36'($signed(in_reg[15:0])  * $signed(in_reg[15:0]));
        sq_y = 36'($signed(in_reg[31:16]) * $signed(in_reg[31:16]));
        sq_z = 36'($signed(in_reg[47:32]) * $signed(in_reg[47:32]));
        trial = {root_reg, 2'b01};
    end

    logic [17:0] rem_try;
    assign rem_try = {rem_reg, quo_reg[47]} - {2'b0, dvs_reg};

    logic [55:0] rprod;
    assign rprod = quo_reg[23:0] * mul_reg;

    logic [15:0] len16;
    logic [15:0] err_calc;
    assign len16 = root_reg[15:0];
    assign err_calc = (len16 >= ONE_Q12) ? len16 - ONE_Q12 : ONE_Q12 - len16;

    logic [EA:0] efill_inc;
    logic [WA:0] wfill_inc;
    assign efill_inc = (efill_reg < (EA+1)'(ERROR_TAPS)) ? efill_reg + 1'b1 : efill_reg;
    assign wfill_inc = (wfill_reg < (WA+1)'(WEIGHT_TAPS)) ? wfill_reg + 1'b1 : wfill_reg;

    logic [37:0] srem_reg;
    logic [37:0] srem_sh;
    logic [37:0] srem_sub;
    assign srem_sh  = {srem_reg[35:0], quo_reg[47:46]};
    assign srem_sub = srem_sh - {18'd0, trial};

    always_comb begin
        ewr = '{en: 1'b0, data: 16'd0};
        wwr = '{en: 1'b0, data: 16'd0};
        ewaddr = enext(ehead_reg);
        wwaddr = wnext(whead_reg);
        if (state_reg == ST_CLEAR) begin
            ewr.en = cnt_reg < CA'(ERROR_TAPS);
            wwr.en = cnt_reg < CA'(WEIGHT_TAPS);
            ewaddr = EA'(cnt_reg);
            wwaddr = WA'(cnt_reg);
        end else if (state_reg == ST_AVGD && step_reg == 6'd40) begin
            ewr = '{en: 1'b1, data: err_reg};
        end else if (state_reg == ST_OUT) begin
            wwr = '{en: 1'b1, data: raw_reg[15:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            ret_reg       <= ST_IDLE;
            power_reg     <= POWER_RESET;
            enable_reg    <= 1'b1;
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ehead_reg     <= EA'(ERROR_TAPS - 1);
            efill_reg     <= '0;
            whead_reg     <= WA'(WEIGHT_TAPS - 1);
            wfill_reg     <= '0;
            cnt_reg       <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SLERP_POWER:  power_reg  <= cfg_wdata;
                    CFG_ACCEL_ENABLE: enable_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (s_tvalid && s_tready) begin
                in_reg      <= s_tdata;
                in_full_reg <= 1'b1;
            end
            case (state_reg)
                ST_CLEAR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CA'(CLR - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_full_reg && !out_valid_reg) begin
                        if (!enable_reg) begin
                            out_weight_reg <= 17'd0;
                            out_byp_reg    <= 1'b0;
                            out_valid_reg  <= 1'b1;
                            in_full_reg    <= 1'b0;
                        end else begin
                            quo_reg   <= {12'd0, sq_x + sq_y + sq_z};
                            srem_reg  <= '0;
                            root_reg  <= '0;
                            step_reg  <= '0;
                            state_reg <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT: begin
                    // two radicand bits per cycle over the 48-bit radicand
                    quo_reg <= {quo_reg[45:0], 2'b00};
                    if (!srem_sub[37]) begin
                        srem_reg <= srem_sub;
                        root_reg <= {root_reg[16:0], 1'b1};
                    end else begin
                        srem_reg <= srem_sh;
                        root_reg <= {root_reg[16:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd23) begin
                        state_reg <= ST_WAVG;
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        step_reg  <= '0;
                    end
                end
                ST_WAVG: begin
                    if (step_reg == 6'd0) begin
                        err_reg  <= err_calc;
                        step_reg <= 6'd1;
                        cnt_reg  <= '0;
                        if (wfill_reg < (WA+1)'(WEIGHT_TAPS)) begin
                            cnt_reg <= CA'(WEIGHT_TAPS - 1);
                            step_reg <= 6'd2;
                        end
                    end else if (step_reg == 6'd1) begin
                        // read issued for cnt; data arrives next cycle
                        step_reg <= 6'd3;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end else if (step_reg == 6'd2) begin
                        step_reg <= 6'd4;
                    end else if (step_reg == 6'd4) begin
                        avg_reg   <= {1'b0, wrdata};
                        state_reg <= ST_AVGD;
                        step_reg  <= 6'd40;
                    end else begin
                        acc_reg <= acc_reg + 35'(wrdata) *
                                   35'(CA'(WEIGHT_TAPS) - cnt_reg + 1'b1);
                        if (cnt_reg == CA'(WEIGHT_TAPS)) begin
                            quo_reg   <= {13'd0, acc_reg + 35'(wrdata)};
                            mul_reg   <= WREC;
                            step_reg  <= '0;
                            ret_reg   <= ST_AVGD;
                            state_reg <= ST_RECIP;
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                ST_RECIP: begin
                    quo_reg   <= {24'd0, rprod[55:32]};
                    step_reg  <= 6'd39;
                    state_reg <= ret_reg;
                end
                ST_DIV: begin
                    quo_reg <= {quo_reg[46:0], !rem_try[17]};
                    rem_reg <= rem_try[17] ? {rem_reg[15:0], quo_reg[47]} : rem_try[16:0];
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd47) begin
                        state_reg <= ret_reg;
                        step_reg  <= 6'd39;
                    end
                end
                ST_AVGD: begin
                    if (step_reg == 6'd39) begin
                        avg_reg  <= quo_reg[16:0];
                        step_reg <= 6'd40;
                    end else begin
                        ehead_reg <= enext(ehead_reg);
                        efill_reg <= efill_inc;
                        byp_reg   <= ({3'b0, err_reg, 3'b0} > {5'd0, avg_reg});
                        if (({3'b0, err_reg, 3'b0} > {5'd0, avg_reg}) ||
                            efill_inc < (EA+1)'(ERROR_TAPS)) begin
                            quo_reg   <= {32'd0, err_reg};
                            state_reg <= ST_MEAND;
                            step_reg  <= 6'd39;
                        end else begin
                            state_reg <= ST_ESUM;
                            cnt_reg   <= '0;
                            acc_reg   <= '0;
                            step_reg  <= '0;
                        end
                    end
                end
                ST_ESUM: begin
                    // read address cnt issued, data of cnt-1 arrives
                    cnt_reg <= cnt_reg + 1'b1;
                    if (step_reg != 6'd0) begin
                        acc_reg <= acc_reg + 35'(erdata);
                    end
                    step_reg <= 6'd1;
                    if (cnt_reg == CA'(ERROR_TAPS)) begin
                        quo_reg   <= {13'd0, acc_reg + 35'(erdata)};
                        mul_reg   <= EREC;
                        step_reg  <= '0;
                        ret_reg   <= ST_MEAND;
                        state_reg <= ST_RECIP;
                    end
                end
                ST_MEAND: begin
                    // The error magnitude sits in the low bits of quo.
                    if (power_reg == 16'd0) begin
                        raw_reg   <= ONE_Q15;
                        state_reg <= ST_RAWD;
                        step_reg  <= 6'd38;
                    end else begin
                        quo_reg   <= {quo_reg[15:0], 32'd0} >> 17;
                        dvs_reg   <= power_reg;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        ret_reg   <= ST_RAWD;
                        state_reg <= ST_DIV;
                    end
                end
                ST_RAWD: begin
                    if (step_reg == 6'd39) begin
                        raw_reg <= (quo_reg > 48'(ONE_Q15)) ? ONE_Q15 : quo_reg[16:0];
                    end
                    step_reg  <= 6'd0;
                    cnt_reg   <= '0;
                    acc_reg   <= '0;
                    state_reg <= ST_WSUM;
                end
                ST_WSUM: begin
                    if (byp_reg || wfill_reg < (WA+1)'(WEIGHT_TAPS)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        // cnt indexes from oldest; skip oldest (cnt 0)
                        cnt_reg <= cnt_reg + 1'b1;
                        if (step_reg != 6'd0 && cnt_reg >= CA'(2)) begin
                            acc_reg <= acc_reg + 35'(wrdata) *
                                       35'(CA'(WEIGHT_TAPS + 1) - cnt_reg + 1'b1);
                        end
                        step_reg <= 6'd1;
                        if (cnt_reg == CA'(WEIGHT_TAPS)) begin
                            quo_reg <= {13'd0, acc_reg + 35'(wrdata) * 35'd2 + 35'(raw_reg)};
                            mul_reg <= WREC;
                            step_reg <= '0;
                            ret_reg <= ST_FILTD;
                            state_reg <= ST_RECIP;
                        end
                    end
                end
                ST_FILTD: begin
                    raw_reg   <= quo_reg[16:0];
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    whead_reg      <= wnext(whead_reg);
                    wfill_reg      <= wfill_inc;
                    out_weight_reg <= ({1'b0, raw_reg[15:0]} > ONE_Q15) ?
                                      ONE_Q15 : {1'b0, raw_reg[15:0]};
                    out_byp_reg    <= byp_reg;
                    out_valid_reg  <= 1'b1;
                    in_full_reg    <= 1'b0;
                    state_reg      <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/aswf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aswf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
